/* sv/stl_pkg.sv */
// Shared types, codes and character tables for the shell token lexer.
package stl_pkg;

   // Token mode of the lexer
   typedef enum logic [2:0] {
      MODE_NONE = 3'b001,
      MODE_OP   = 3'b010,
      MODE_WORD = 3'b100
   } mode_type;

   // Assignment-word tracking
   typedef enum logic [3:0] {
      ASG_START = 4'b0001,
      ASG_NAME  = 4'b0010,
      ASG_EQ    = 4'b0100,
      ASG_NO    = 4'b1000
   } asg_type;

   // Token kinds
   localparam logic [2:0] KIND_NEWLINE  = 3'd0;
   localparam logic [2:0] KIND_OPERATOR = 3'd1;
   localparam logic [2:0] KIND_WORD     = 3'd2;
   localparam logic [2:0] KIND_ASSIGN   = 3'd3;
   localparam logic [2:0] KIND_IO_NUM   = 3'd4;
   localparam logic [2:0] KIND_RESERVED = 3'd5;

   // Operator codes
   localparam logic [4:0] OP_LESS        = 5'd0;
   localparam logic [4:0] OP_GREAT       = 5'd1;
   localparam logic [4:0] OP_DLESS       = 5'd2;
   localparam logic [4:0] OP_DGREAT      = 5'd3;
   localparam logic [4:0] OP_LESSAND     = 5'd4;
   localparam logic [4:0] OP_GREATAND    = 5'd5;
   localparam logic [4:0] OP_LESSGREAT   = 5'd6;
   localparam logic [4:0] OP_DLESSDASH   = 5'd7;
   localparam logic [4:0] OP_CLOBBER     = 5'd8;
   localparam logic [4:0] OP_OR_IF       = 5'd9;
   localparam logic [4:0] OP_AND_IF      = 5'd10;
   localparam logic [4:0] OP_PIPE        = 5'd11;
   localparam logic [4:0] OP_BANG        = 5'd12;
   localparam logic [4:0] OP_AMP         = 5'd13;
   localparam logic [4:0] OP_SEMI        = 5'd14;
   localparam logic [4:0] OP_BRACE_OPEN  = 5'd15;
   localparam logic [4:0] OP_BRACE_CLOSE = 5'd16;

   // Characters
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_LT     = 8'h3C;
   localparam logic [7:0] CH_GT     = 8'h3E;
   localparam logic [7:0] CH_PIPE   = 8'h7C;
   localparam logic [7:0] CH_BANG   = 8'h21;
   localparam logic [7:0] CH_AMP    = 8'h26;
   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;
   localparam logic [7:0] CH_DASH   = 8'h2D;
   localparam logic [7:0] CH_UNDER  = 8'h5F;
   localparam logic [7:0] CH_EQUAL  = 8'h3D;

   localparam int KEY_COUNT = 13;
   localparam int HEAD_BYTES = 5;

   // Keywords packed first byte lowest, with their lengths
   localparam logic [39:0] KEY_HEAD [KEY_COUNT] = '{
      40'h00_65_73_61_63,   // case
      40'h00_00_00_6F_64,   // do
      40'h00_65_6E_6F_64,   // done
      40'h00_66_69_6C_65,   // elif
      40'h00_65_73_6C_65,   // else
      40'h00_63_61_73_65,   // esac
      40'h00_00_00_69_66,   // fi
      40'h00_00_72_6F_66,   // for
      40'h00_00_00_66_69,   // if
      40'h00_00_00_6E_69,   // in
      40'h00_6E_65_68_74,   // then
      40'h6C_69_74_6E_75,   // until
      40'h65_6C_69_68_77    // while
   };
   localparam logic [2:0] KEY_LEN [KEY_COUNT] = '{
      3'd4, 3'd2, 3'd4, 3'd4, 3'd4, 3'd4, 3'd2, 3'd3, 3'd2, 3'd2, 3'd4, 3'd5, 3'd5
   };

   typedef struct packed {
      logic       hit;
      logic [4:0] code;
   } hit_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [4:0] code;
      logic [7:0] length;
      logic       last;
   } result_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
   endfunction

   function automatic hit_type op_start(input logic [7:0] c);
      hit_type r;
      r.hit  = 1'b1;
      r.code = OP_LESS;
      unique case (c)
         CH_LT:     r.code = OP_LESS;
         CH_GT:     r.code = OP_GREAT;
         CH_PIPE:   r.code = OP_PIPE;
         CH_BANG:   r.code = OP_BANG;
         CH_AMP:    r.code = OP_AMP;
         CH_SEMI:   r.code = OP_SEMI;
         CH_LBRACE: r.code = OP_BRACE_OPEN;
         CH_RBRACE: r.code = OP_BRACE_CLOSE;
         default:   r.hit  = 1'b0;
      endcase
      return r;
   endfunction

   function automatic hit_type op_extend(input logic [4:0] p, input logic [7:0] c);
      hit_type r;
      r.hit  = 1'b1;
      r.code = OP_LESS;
      if (p == OP_LESS && c == CH_LT)         r.code = OP_DLESS;
      else if (p == OP_LESS && c == CH_AMP)   r.code = OP_LESSAND;
      else if (p == OP_LESS && c == CH_GT)    r.code = OP_LESSGREAT;
      else if (p == OP_GREAT && c == CH_GT)   r.code = OP_DGREAT;
      else if (p == OP_GREAT && c == CH_AMP)  r.code = OP_GREATAND;
      else if (p == OP_GREAT && c == CH_PIPE) r.code = OP_CLOBBER;
      else if (p == OP_DLESS && c == CH_DASH) r.code = OP_DLESSDASH;
      else if (p == OP_PIPE && c == CH_PIPE)  r.code = OP_OR_IF;
      else if (p == OP_AMP && c == CH_AMP)    r.code = OP_AND_IF;
      else                                    r.hit  = 1'b0;
      return r;
   endfunction

   // len_ok: the word is at most five bytes long
   function automatic hit_type key_lookup(input logic [39:0] head, input logic len_ok,
                                          input logic [2:0] len);
      hit_type r;
      r.hit  = 1'b0;
      r.code = 5'd0;
      for (int k = 0; k < KEY_COUNT; k++) begin
         if (len_ok && len == KEY_LEN[k] && head == KEY_HEAD[k]) begin
            r.hit  = 1'b1;
            r.code = 5'(k);
         end
      end
      return r;
   endfunction

endpackage

/* sv/shell_token_lexer_top.sv */
// Shell token lexer: one byte per item in, classified tokens out.
//
// Usage:
//  req_* carries one input character per item (req_tdata is the byte).
//  rsp_* carries tokens: rsp_tdata holds kind, code and length, rsp_tlast
//  marks the last token that one character caused (a character causes zero,
//  one or two tokens).
//  A token caused by a character is on rsp_* the cycle after the character
//  is accepted when no earlier token is waiting. Throughput: one character
//  per cycle while each causes at most one token and the receiver takes
//  them; a character that causes two tokens leaves two in the three-entry
//  result queue, so req_tready drops until the first of them drains.
//  req_tready is high while the queue holds at most one token, so the input
//  side never depends combinationally on rsp_tready.
//  When the receiver stalls, tokens wait in the queue and input is refused
//  once two or more are waiting.
//  Reset clears the lexer state (no token in progress, outside a command)
//  and empties the queue.
module shell_token_lexer_top #(
   parameter int MAX_TOKEN_LEN = 255
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] ch
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [2:0] kind, [7:3] code, [15:8] length
   output logic        rsp_tlast    // last
);

   localparam int LenW = $clog2(MAX_TOKEN_LEN + 1);
   localparam int QDepth = 3;

   stl_pkg::mode_type     mode_ff, mode_in;
   logic [4:0]            prefix_ff, prefix_in;
   logic [LenW-1:0]       len_ff, len_in;
   logic [39:0]           head_ff, head_in;
   logic                  digits_ff, digits_in;
   stl_pkg::asg_type      track_ff, track_in;
   logic                  incmd_ff, incmd_in;

   stl_pkg::result_type   q_ff [QDepth];
   stl_pkg::result_type   q_in [QDepth];
   logic [1:0]            cnt_ff, cnt_in;

   stl_pkg::result_type   res [2];
   logic [1:0]            nres;
   logic                  accept, pop;
   logic [7:0]            ch;
   logic [7:0]            len_sat;
   stl_pkg::hit_type      kw;
   stl_pkg::hit_type      ext, start;
   stl_pkg::result_type   word_plain, word_redir;

   assign ch     = req_tdata;
   assign accept = req_tvalid && req_tready;
   assign pop    = rsp_tvalid && rsp_tready;

   assign req_tready = (cnt_ff < 2'd2);
   assign rsp_tvalid = (cnt_ff != 2'd0);
   assign rsp_tdata  = {q_ff[0].length, q_ff[0].code, q_ff[0].kind};
   assign rsp_tlast  = q_ff[0].last;

   assign len_sat = (32'(len_ff) > 32'd255) ? 8'hFF : 8'(len_ff);
   assign kw      = stl_pkg::key_lookup(head_ff, 32'(len_ff) <= 32'd5, len_ff[2:0]);
   assign ext     = stl_pkg::op_extend(prefix_ff, ch);
   assign start   = stl_pkg::op_start(ch);

   function automatic stl_pkg::result_type word_class(input logic redir);
      stl_pkg::result_type r;
      r.length = len_sat;
      r.code   = 5'd0;
      r.last   = 1'b0;
      if (digits_ff && redir) begin
         r.kind = stl_pkg::KIND_IO_NUM;
      end else if (!incmd_ff && track_ff == stl_pkg::ASG_EQ) begin
         r.kind = stl_pkg::KIND_ASSIGN;
      end else if (!incmd_ff && kw.hit) begin
         r.kind = stl_pkg::KIND_RESERVED;
         r.code = kw.code;
      end else begin
         r.kind = stl_pkg::KIND_WORD;
      end
      return r;
   endfunction

   always_comb begin
      word_plain = word_class(1'b0);
      word_redir = word_class(1'b1);
   end

   // Lexer step for the character on req_tdata
   always_comb begin : lex_step
      logic consumed;
      stl_pkg::result_type wres;
      stl_pkg::result_type nl;
      consumed  = 1'b0;
      wres      = (ch == stl_pkg::CH_LT || ch == stl_pkg::CH_GT) ? word_redir : word_plain;
      nl.kind   = stl_pkg::KIND_NEWLINE;
      nl.code   = 5'd0;
      nl.length = 8'd1;
      nl.last   = 1'b0;
      mode_in   = mode_ff;
      prefix_in = prefix_ff;
      len_in    = len_ff;
      head_in   = head_ff;
      digits_in = digits_ff;
      track_in  = track_ff;
      incmd_in  = incmd_ff;
      res[0]    = nl;
      res[1]    = nl;
      nres      = 2'd0;

      if (mode_ff == stl_pkg::MODE_OP) begin
         if (ch != stl_pkg::CH_LF && ext.hit) begin
            prefix_in = ext.code;
            if (len_ff < LenW'(MAX_TOKEN_LEN)) len_in = len_ff + 1'b1;
            consumed = 1'b1;
         end else begin
            res[0].kind   = stl_pkg::KIND_OPERATOR;
            res[0].code   = prefix_ff;
            res[0].length = len_sat;
            nres          = 2'd1;
            if (prefix_ff == stl_pkg::OP_AMP || prefix_ff == stl_pkg::OP_SEMI) incmd_in = 1'b0;
            mode_in = stl_pkg::MODE_NONE;
         end
      end

      if (!consumed) begin
         if (ch == stl_pkg::CH_LF) begin
            if (mode_ff == stl_pkg::MODE_WORD) begin
               res[0] = word_plain;
               if (word_plain.kind == stl_pkg::KIND_WORD) incmd_in = 1'b1;
               mode_in = stl_pkg::MODE_NONE;
               nres    = 2'd1;
            end
            res[nres[0]] = nl;
            nres         = nres + 2'd1;
         end else if (start.hit) begin
            if (mode_ff == stl_pkg::MODE_WORD) begin
               res[0] = wres;
               if (wres.kind == stl_pkg::KIND_WORD) incmd_in = 1'b1;
               nres = 2'd1;
            end
            mode_in   = stl_pkg::MODE_OP;
            prefix_in = start.code;
            len_in    = LenW'(1);
         end else if (ch == stl_pkg::CH_SPACE || ch == stl_pkg::CH_TAB) begin
            if (mode_ff == stl_pkg::MODE_WORD) begin
               res[0] = word_plain;
               if (word_plain.kind == stl_pkg::KIND_WORD) incmd_in = 1'b1;
               mode_in = stl_pkg::MODE_NONE;
               nres    = 2'd1;
            end
         end else begin
            // Word byte: open a fresh word if none is in progress
            if (mode_ff != stl_pkg::MODE_WORD) begin
               mode_in   = stl_pkg::MODE_WORD;
               len_in    = '0;
               head_in   = '0;
               digits_in = 1'b1;
               track_in  = stl_pkg::ASG_START;
            end
            if (32'(len_in) < stl_pkg::HEAD_BYTES) begin
               head_in = head_in | ({32'd0, ch} << (8 * len_in[2:0]));
            end
            if (!stl_pkg::is_digit(ch)) digits_in = 1'b0;
            unique case (track_in) inside
               stl_pkg::ASG_START: begin
                  track_in = (stl_pkg::is_alpha(ch) || ch == stl_pkg::CH_UNDER) ?
                             stl_pkg::ASG_NAME : stl_pkg::ASG_NO;
               end
               stl_pkg::ASG_NAME: begin
                  if (ch == stl_pkg::CH_EQUAL) begin
                     track_in = stl_pkg::ASG_EQ;
                  end else if (!(stl_pkg::is_alpha(ch) || stl_pkg::is_digit(ch) ||
                                 ch == stl_pkg::CH_UNDER)) begin
                     track_in = stl_pkg::ASG_NO;
                  end
               end
               stl_pkg::ASG_EQ, stl_pkg::ASG_NO: begin
                  track_in = track_in;
               end
               default: begin
                  track_in = stl_pkg::ASG_NO;
               end
            endcase
            if (len_in < LenW'(MAX_TOKEN_LEN)) len_in = len_in + 1'b1;
         end
      end

      if (nres == 2'd2) res[1].last = 1'b1;
      else if (nres == 2'd1) res[0].last = 1'b1;
   end

   // Result queue: drop the head on pop, append this item's tokens
   always_comb begin : queue_next
      logic [1:0] base;
      base = cnt_ff - {1'b0, pop};
      for (int i = 0; i < QDepth; i++) q_in[i] = q_ff[i];
      if (pop) begin
         for (int i = 0; i < QDepth - 1; i++) q_in[i] = q_ff[i + 1];
      end
      cnt_in = base;
      if (accept) begin
         if (nres != 2'd0) q_in[base] = res[0];
         if (nres == 2'd2) q_in[base + 2'd1] = res[1];
         cnt_in = base + nres;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= stl_pkg::MODE_NONE;
         prefix_ff <= stl_pkg::OP_LESS;
         len_ff    <= '0;
         head_ff   <= '0;
         digits_ff <= 1'b1;
         track_ff  <= stl_pkg::ASG_START;
         incmd_ff  <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         if (accept) begin
            mode_ff   <= mode_in;
            prefix_ff <= prefix_in;
            len_ff    <= len_in;
            head_ff   <= head_in;
            digits_ff <= digits_in;
            track_ff  <= track_in;
            incmd_ff  <= incmd_in;
         end
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < QDepth; i++) q_ff[i] <= q_in[i];
   end

   a_word_len: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == stl_pkg::MODE_WORD) |-> (len_ff != '0))
      else $error("word in progress with zero length");

   a_op_len: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == stl_pkg::MODE_OP) |-> (len_ff != '0 && 32'(len_ff) <= 32'd3))
      else $error("operator length out of range");

   a_op_code: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == stl_pkg::MODE_OP) |-> (prefix_ff <= stl_pkg::OP_BRACE_CLOSE))
      else $error("operator prefix code out of range");

   a_digits_track: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == stl_pkg::MODE_WORD && digits_ff) |-> (track_ff == stl_pkg::ASG_NO))
      else $error("all-digit word tracked as a name");

   a_queue_room: assert property (@(posedge clock) disable iff (reset)
      accept |=> (cnt_ff != 2'd0 || $past(nres) == 2'd0))
      else $error("tokens of an accepted item lost");

endmodule
